@@ rtl/gcd_pkg.sv @@
// Shared types and constants for the locator distance core.
// Used by gcd_front, gcd_queue, gcd_back and the top level.
`default_nettype none
package gcd_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int NLANE = 4;
  localparam int AW = 20;
  localparam int FW = 13;
  localparam int ZW = 31;
  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  localparam logic [19:0] TURN_OFFSET = 20'd276480;
  localparam logic [17:0] REDUCE_RECIP = 18'd248551;
  localparam logic [15:0] FULL_TURN = 16'd17280;
  localparam logic [15:0] QUARTER_TURN = 16'd4320;
  localparam logic [18:0] CONV_A = 19'd390423;
  localparam logic [31:0] CONV_B = 32'd1233683875;
  localparam logic [31:0] CONV_CQ = 32'd2339430160;
  localparam logic [31:0] CONV_D = 32'd2264924160;
  localparam logic [31:0] CONV_DH = 32'd1132462080;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;
  localparam logic [13:0] DIST_SCALE = 14'd12742;
  localparam logic [18:0] DIST_MAX = 19'd320300;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic [1:0]    quad;
    logic [ZW-1:0] z;
  } angle_t;

  typedef struct packed {
    angle_t [NLANE-1:0] ang;
  } item_t;

endpackage
`default_nettype wire

@@ rtl/gcd_front.sv @@
// Front end: decodes both locators, forms the four angles and reduces each to
// a quadrant and a Q1.30 first-quadrant angle. Depends on gcd_pkg.
`default_nettype none
module gcd_front import gcd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [47:0] in_locator_a,
  input  wire logic [2:0]  in_length_a,
  input  wire logic [47:0] in_locator_b,
  input  wire logic [2:0]  in_length_b,
  output logic             push_valid,
  input  wire logic        push_ready,
  output item_t            push_item
);

  localparam int NF = 7;

  typedef struct packed {
    logic signed [AW-1:0] lat;
    logic signed [AW-1:0] lon;
  } coord_t;

  function automatic logic signed [AW-1:0] bx(input logic [7:0] b);
    return {{(AW-8){1'b0}}, b};
  endfunction

  function automatic coord_t decode(input logic [47:0] loc, input logic [2:0] len);
    coord_t c;
    logic [7:0] c0, c1, c4, c5;
    c0 = loc[47:40];
    c1 = loc[39:32];
    c4 = loc[15:8];
    c5 = loc[7:0];
    if (c0 >= 8'h61 && c0 <= 8'h7A) c0 = c0 - 8'd32;
    if (c1 >= 8'h61 && c1 <= 8'h7A) c1 = c1 - 8'd32;
    if (c4 >= 8'h41 && c4 <= 8'h5A) c4 = c4 + 8'd32;
    if (c5 >= 8'h41 && c5 <= 8'h5A) c5 = c5 + 8'd32;
    c.lon = (bx(c0) - 20'sd65) * 20'sd480 + (bx(loc[31:24]) - 20'sd48) * 20'sd48 - 20'sd4296;
    c.lat = (bx(c1) - 20'sd65) * 20'sd240 + (bx(loc[23:16]) - 20'sd48) * 20'sd24 - 20'sd2148;
    if (len >= 3'd6) begin
      c.lon = c.lon + (bx(c4) - 20'sd97) * 20'sd2;
      c.lat = c.lat + (bx(c5) - 20'sd97);
    end
    if (len < 3'd4) begin
      c.lat = '0;
      c.lon = '0;
    end
    return c;
  endfunction

  logic [NF-1:0] vf_r;
  logic          en_f;

  logic signed [AW-1:0] u_r   [NLANE];
  logic [18:0]          v_r   [NLANE];
  logic [4:0]           qm_r  [NLANE];
  logic [15:0]          r0_r  [NLANE];
  logic [FW-1:0]        f_r   [NLANE];
  logic [43:0]          fb_r  [NLANE];
  logic [43:0]          fb6_r [NLANE];
  logic [FW-1:0]        q0_r  [NLANE];
  logic [FW-1:0]        q06_r [NLANE];
  logic [30:0]          fa_r  [NLANE];
  logic [30:0]          fa6_r [NLANE];
  logic [44:0]          q0d_r [NLANE];
  logic [ZW-1:0]        z_r   [NLANE];
  logic [1:0]           qd4_r [NLANE];
  logic [1:0]           qd5_r [NLANE];
  logic [1:0]           qd6_r [NLANE];
  logic [1:0]           qd7_r [NLANE];

  coord_t ca, cb;
  logic signed [AW-1:0] u_nxt  [NLANE];
  logic [18:0]          v_nxt  [NLANE];
  logic [4:0]           qm_nxt [NLANE];
  logic [15:0]          r0_nxt [NLANE];
  logic [FW-1:0]        f_nxt  [NLANE];
  logic [1:0]           qd_nxt [NLANE];
  logic [43:0]          fb_nxt [NLANE];
  logic [FW-1:0]        q0_nxt [NLANE];
  logic [30:0]          fa_nxt [NLANE];
  logic [44:0]          q0d_nxt [NLANE];
  logic [ZW-1:0]        z_nxt  [NLANE];

  assign en_f = !vf_r[NF-1] || push_ready;
  assign in_ready = en_f;
  assign push_valid = vf_r[NF-1];

  always_comb begin
    ca = decode(in_locator_a, in_length_a);
    cb = decode(in_locator_b, in_length_b);
    u_nxt[0] = cb.lat - ca.lat;
    u_nxt[1] = cb.lon - ca.lon;
    u_nxt[2] = ca.lat <<< 1;
    u_nxt[3] = cb.lat <<< 1;
  end

  always_comb begin
    logic signed [20:0] vs;
    logic [36:0]        pm;
    logic [19:0]        rd;
    logic [15:0]        rr;
    logic [44:0]        pc;
    logic signed [46:0] rem;
    logic [FW-1:0]      qc;
    for (int l = 0; l < NLANE; l++) begin
      vs = 21'(u_r[l]) + 21'(TURN_OFFSET);
      v_nxt[l] = vs[18:0];
      pm = 37'(v_nxt[l]) * 37'(REDUCE_RECIP);
      qm_nxt[l] = pm[36:32];

      rd = 20'(v_r[l]) - 20'(qm_r[l]) * 20'(FULL_TURN);
      r0_nxt[l] = rd[15:0];

      rr = (r0_r[l] >= FULL_TURN) ? r0_r[l] - FULL_TURN : r0_r[l];
      priority if (rr >= 16'd12960) begin
        qd_nxt[l] = 2'd3;
        rr = rr - 16'd12960;
      end else if (rr >= 16'd8640) begin
        qd_nxt[l] = 2'd2;
        rr = rr - 16'd8640;
      end else if (rr >= QUARTER_TURN) begin
        qd_nxt[l] = 2'd1;
        rr = rr - QUARTER_TURN;
      end else begin
        qd_nxt[l] = 2'd0;
      end
      f_nxt[l] = rr[FW-1:0];

      fb_nxt[l] = 44'(f_r[l]) * 44'(CONV_B);
      pc = 45'(f_r[l]) * 45'(CONV_CQ) + (45'(1) << 31);
      q0_nxt[l] = pc[44:32];
      fa_nxt[l] = 31'(f_r[l]) * 31'(CONV_A);

      q0d_nxt[l] = 45'(q0_r[l]) * 45'(CONV_D);

      rem = $signed({3'b000, fb6_r[l]}) + $signed({15'd0, CONV_DH})
          - $signed({2'b00, q0d_r[l]});
      if (rem < 0) begin
        qc = q06_r[l] - 13'd1;
      end else if (rem >= $signed({15'd0, CONV_D})) begin
        qc = q06_r[l] + 13'd1;
      end else begin
        qc = q06_r[l];
      end
      z_nxt[l] = fa6_r[l] + 31'(qc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= '0;
    end else if (en_f) begin
      vf_r <= {vf_r[NF-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      for (int l = 0; l < NLANE; l++) begin
        u_r[l]   <= u_nxt[l];
        v_r[l]   <= v_nxt[l];
        qm_r[l]  <= qm_nxt[l];
        r0_r[l]  <= r0_nxt[l];
        f_r[l]   <= f_nxt[l];
        qd4_r[l] <= qd_nxt[l];
        fb_r[l]  <= fb_nxt[l];
        q0_r[l]  <= q0_nxt[l];
        fa_r[l]  <= fa_nxt[l];
        qd5_r[l] <= qd4_r[l];
        q0d_r[l] <= q0d_nxt[l];
        fb6_r[l] <= fb_r[l];
        q06_r[l] <= q0_r[l];
        fa6_r[l] <= fa_r[l];
        qd6_r[l] <= qd5_r[l];
        z_r[l]   <= z_nxt[l];
        qd7_r[l] <= qd6_r[l];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      push_item.ang[l].quad = qd7_r[l];
      push_item.ang[l].z    = z_r[l];
    end
  end

endmodule
`default_nettype wire

@@ rtl/gcd_queue.sv @@
// Short queue of reduced angle sets between front and back end.
// Depends on gcd_pkg for the item type and depth.
`default_nettype none
module gcd_queue import gcd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire item_t push_item,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output item_t      pop_item
);

  item_t          mem_r [QDEPTH];
  logic [QAW-1:0] wptr_r, rptr_r;
  logic [QAW:0]   cnt_r;
  logic           push, pop;

  assign push_ready = cnt_r != (QAW+1)'(QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;
  assign pop_item = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop) rptr_r <= rptr_r + 1'b1;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH)) else $error("queue count over depth");
  a_ptr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (wptr_r - rptr_r) == cnt_r[QAW-1:0]) else $error("queue pointers disagree with count");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("queue lost a transfer");

endmodule
`default_nettype wire

@@ rtl/gcd_back.sv @@
// Back end: CORDIC sine/cosine, haversine products, square roots, CORDIC
// atan2 and distance scaling, all stalling together. Depends on gcd_pkg.
`default_nettype none
module gcd_back import gcd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        pop_valid,
  output logic             pop_ready,
  input  wire item_t       pop_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [18:0]      out_distance_km_q4
);

  localparam int N = CORDIC_STAGES;
  localparam int LB = 2 * N + 39;
  localparam int SQS = 31;

  function automatic logic signed [33:0] mul_q30(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
    logic [33:0] ma, mb, m;
    logic [67:0] p;
    ma = a[33] ? 34'(-a) : 34'(a);
    mb = b[33] ? 34'(-b) : 34'(b);
    p = 68'(ma) * 68'(mb) + (68'(1) << 29);
    m = p[63:30];
    return (a[33] ^ b[33]) ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [33:0] pick(input logic [1:0] q, input logic is_cos,
                                              input logic signed [33:0] x,
                                              input logic signed [33:0] y);
    logic signed [33:0] r;
    unique case ({is_cos, q})
      3'b000: r = y;
      3'b001: r = x;
      3'b010: r = -y;
      3'b011: r = -x;
      3'b100: r = x;
      3'b101: r = -y;
      3'b110: r = -x;
      3'b111: r = y;
      default: r = y;
    endcase
    return r;
  endfunction

  logic          en;
  logic [LB-1:0] vb_r;

  logic signed [33:0] rx_r [N+1][NLANE];
  logic signed [33:0] ry_r [N+1][NLANE];
  logic signed [33:0] rz_r [N+1][NLANE];
  logic [1:0]         rq_r [N+1][NLANE];
  logic signed [33:0] rx_nxt [N+1][NLANE];
  logic signed [33:0] ry_nxt [N+1][NLANE];
  logic signed [33:0] rz_nxt [N+1][NLANE];

  logic signed [33:0] sel_r [NLANE];
  logic signed [33:0] plat_r, plon_r, pc_r, plat2_r, p2_r;

  logic [61:0] sqv_r [SQS+1][2];
  logic [61:0] sqs_r [SQS+1][2];
  logic [61:0] sqv_nxt [SQS+1][2];
  logic [61:0] sqs_nxt [SQS+1][2];
  logic [30:0] a_nxt;

  logic signed [33:0] ax_r [N+1];
  logic signed [33:0] ay_r [N+1];
  logic signed [33:0] az_r [N+1];
  logic signed [33:0] ax_nxt [N+1];
  logic signed [33:0] ay_nxt [N+1];
  logic signed [33:0] az_nxt [N+1];

  logic [46:0] dp_r;
  logic [18:0] out_r;
  logic [18:0] out_nxt;

  assign en = !vb_r[LB-1] || out_ready;
  assign pop_ready = en;
  assign out_valid = vb_r[LB-1];
  assign out_distance_km_q4 = out_r;

  always_comb begin
    logic signed [33:0] at;
    for (int k = 0; k <= N; k++) begin
      for (int l = 0; l < NLANE; l++) begin
        rx_nxt[k][l] = rx_r[k][l];
        ry_nxt[k][l] = ry_r[k][l];
        rz_nxt[k][l] = rz_r[k][l];
      end
    end
    for (int k = 0; k < N; k++) begin
      at = $signed({2'b00, ATAN_TAB[k]});
      for (int l = 0; l < NLANE; l++) begin
        if (!rz_r[k][l][33]) begin
          rx_nxt[k+1][l] = rx_r[k][l] - (ry_r[k][l] >>> k);
          ry_nxt[k+1][l] = ry_r[k][l] + (rx_r[k][l] >>> k);
          rz_nxt[k+1][l] = rz_r[k][l] - at;
        end else begin
          rx_nxt[k+1][l] = rx_r[k][l] + (ry_r[k][l] >>> k);
          ry_nxt[k+1][l] = ry_r[k][l] - (rx_r[k][l] >>> k);
          rz_nxt[k+1][l] = rz_r[k][l] + at;
        end
      end
    end
  end

  always_comb begin
    logic signed [34:0] asum;
    asum = 35'(plat2_r) + 35'(p2_r);
    if (asum < 0) begin
      a_nxt = '0;
    end else if (asum > 35'sd1073741824) begin
      a_nxt = 31'd1073741824;
    end else begin
      a_nxt = asum[30:0];
    end
  end

  always_comb begin
    logic [61:0] bt, tr;
    for (int j = 0; j <= SQS; j++) begin
      for (int s = 0; s < 2; s++) begin
        sqv_nxt[j][s] = sqv_r[j][s];
        sqs_nxt[j][s] = sqs_r[j][s];
      end
    end
    for (int j = 0; j < SQS; j++) begin
      bt = 62'(1) << (60 - 2 * j);
      for (int s = 0; s < 2; s++) begin
        tr = sqs_r[j][s] + bt;
        if (sqv_r[j][s] >= tr) begin
          sqv_nxt[j+1][s] = sqv_r[j][s] - tr;
          sqs_nxt[j+1][s] = (sqs_r[j][s] >> 1) + bt;
        end else begin
          sqv_nxt[j+1][s] = sqv_r[j][s];
          sqs_nxt[j+1][s] = sqs_r[j][s] >> 1;
        end
      end
    end
  end

  always_comb begin
    logic signed [33:0] at;
    for (int k = 0; k <= N; k++) begin
      ax_nxt[k] = ax_r[k];
      ay_nxt[k] = ay_r[k];
      az_nxt[k] = az_r[k];
    end
    for (int k = 0; k < N; k++) begin
      at = $signed({2'b00, ATAN_TAB[k]});
      if (ay_r[k] > 0) begin
        ax_nxt[k+1] = ax_r[k] + (ay_r[k] >>> k);
        ay_nxt[k+1] = ay_r[k] - (ax_r[k] >>> k);
        az_nxt[k+1] = az_r[k] + at;
      end else begin
        ax_nxt[k+1] = ax_r[k] - (ay_r[k] >>> k);
        ay_nxt[k+1] = ay_r[k] + (ax_r[k] >>> k);
        az_nxt[k+1] = az_r[k] - at;
      end
    end
  end

  always_comb begin
    logic [46:0] rd;
    rd = dp_r + (47'(1) << 25);
    if (rd[46:26] > 21'(DIST_MAX)) begin
      out_nxt = DIST_MAX;
    end else begin
      out_nxt = rd[44:26];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= '0;
    end else if (en) begin
      vb_r <= {vb_r[LB-2:0], pop_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NLANE; l++) begin
        rx_r[0][l] <= CORDIC_GAIN;
        ry_r[0][l] <= '0;
        rz_r[0][l] <= $signed({3'b000, pop_item.ang[l].z});
        rq_r[0][l] <= pop_item.ang[l].quad;
        for (int k = 0; k < N; k++) begin
          rx_r[k+1][l] <= rx_nxt[k+1][l];
          ry_r[k+1][l] <= ry_nxt[k+1][l];
          rz_r[k+1][l] <= rz_nxt[k+1][l];
          rq_r[k+1][l] <= rq_r[k][l];
        end
      end
      sel_r[0] <= pick(rq_r[N][0], 1'b0, rx_r[N][0], ry_r[N][0]);
      sel_r[1] <= pick(rq_r[N][1], 1'b0, rx_r[N][1], ry_r[N][1]);
      sel_r[2] <= pick(rq_r[N][2], 1'b1, rx_r[N][2], ry_r[N][2]);
      sel_r[3] <= pick(rq_r[N][3], 1'b1, rx_r[N][3], ry_r[N][3]);
      plat_r  <= mul_q30(sel_r[0], sel_r[0]);
      plon_r  <= mul_q30(sel_r[1], sel_r[1]);
      pc_r    <= mul_q30(sel_r[2], sel_r[3]);
      plat2_r <= plat_r;
      p2_r    <= mul_q30(pc_r, plon_r);
      sqv_r[0][0] <= {1'b0, a_nxt, 30'd0};
      sqv_r[0][1] <= {1'b0, 31'd1073741824 - a_nxt, 30'd0};
      sqs_r[0][0] <= '0;
      sqs_r[0][1] <= '0;
      for (int j = 0; j < SQS; j++) begin
        for (int s = 0; s < 2; s++) begin
          sqv_r[j+1][s] <= sqv_nxt[j+1][s];
          sqs_r[j+1][s] <= sqs_nxt[j+1][s];
        end
      end
      ay_r[0] <= $signed({2'b00, sqs_r[SQS][0][31:0]});
      ax_r[0] <= $signed({2'b00, sqs_r[SQS][1][31:0]});
      az_r[0] <= '0;
      for (int k = 0; k < N; k++) begin
        ax_r[k+1] <= ax_nxt[k+1];
        ay_r[k+1] <= ay_nxt[k+1];
        az_r[k+1] <= az_nxt[k+1];
      end
      dp_r  <= az_r[N][33] ? '0 : 47'(az_r[N][32:0]) * 47'(DIST_SCALE);
      out_r <= out_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/locator_great_circle_distance_core.sv @@
// Top level of the locator great-circle distance core: front end, angle queue
// and back end. Depends on gcd_pkg, gcd_front, gcd_queue and gcd_back.
//
//   channel   handshake              payload
//   in        in_valid / in_ready    in_locator_a, in_length_a, in_locator_b, in_length_b
//   out       out_valid / out_ready  out_distance_km_q4
//
// One locator pair is accepted per cycle while in_ready is high; one distance leaves
// per cycle while out_ready is high. The path holds 7 front stages, the queue and
// 2*CORDIC_STAGES+39 back stages, set by the CORDIC rotation and vectoring chains
// and the 31-step square root pipeline.
// Reset (rst_n low, synchronous) empties both pipelines and the queue.
// A stalled output holds the back end; the queue absorbs front-end transfers until full.
`default_nettype none
module locator_great_circle_distance_core import gcd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [47:0] in_locator_a,
  input  wire logic [2:0]  in_length_a,
  input  wire logic [47:0] in_locator_b,
  input  wire logic [2:0]  in_length_b,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [18:0]      out_distance_km_q4
);

  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_item, pop_item;

  gcd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_locator_a (in_locator_a),
    .in_length_a  (in_length_a),
    .in_locator_b (in_locator_b),
    .in_length_b  (in_length_b),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  gcd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  gcd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .pop_valid          (pop_valid),
    .pop_ready          (pop_ready),
    .pop_item           (pop_item),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_distance_km_q4 (out_distance_km_q4)
  );

endmodule
`default_nettype wire

@@ tb/sv/locator_great_circle_distance_checker.sv @@
// Checker for the locator great-circle distance core: watches both channels,
// predicts each distance and compares it with the result. Depends on gcd_pkg.
module locator_great_circle_distance_checker import gcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [47:0] in_locator_a,
  input  logic [2:0]  in_length_a,
  input  logic [47:0] in_locator_b,
  input  logic [2:0]  in_length_b,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [18:0] out_distance_km_q4,
  output int          fail_count,
  output int          pending,
  output int          result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE = 64'sd1 << 30;
  localparam longint unsigned PI48 = 64'h3243F6A8885A3;

  logic [18:0] distance_q[$];

  function automatic longint tobyte(logic [47:0] loc, int k);
    return longint'(loc[(5 - k) * 8 +: 8]);
  endfunction

  function automatic void decode_locator(input logic [47:0] loc, input logic [2:0] len,
                                         output longint lat, output longint lon);
    longint c0, c1, c4, c5;
    if (len < 3'd4) begin
      lat = 0;
      lon = 0;
      return;
    end
    c0 = tobyte(loc, 0);
    c1 = tobyte(loc, 1);
    if (c0 >= 97 && c0 <= 122) c0 -= 32;
    if (c1 >= 97 && c1 <= 122) c1 -= 32;
    lon = (c0 - 65) * 480 + (tobyte(loc, 2) - 48) * 48 - 4320 + 24;
    lat = (c1 - 65) * 240 + (tobyte(loc, 3) - 48) * 24 - 2160 + 12;
    if (len >= 3'd6) begin
      c4 = tobyte(loc, 4);
      c5 = tobyte(loc, 5);
      if (c4 >= 65 && c4 <= 90) c4 += 32;
      if (c5 >= 65 && c5 <= 90) c5 += 32;
      lon += (c4 - 97) * 2;
      lat += c5 - 97;
    end
  endfunction

  function automatic longint mul_round(longint a, longint b);
    longint unsigned ma, mb, p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = (ma * mb + (64'd1 << 29)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // angle in 1/48 degree
  function automatic void rotate(input longint u, output longint s, output longint c);
    longint r, x, y, z, dx, dy;
    longint unsigned f;
    int q;
    r = u % 17280;
    if (r < 0) r += 17280;
    q = int'(r / 4320);
    f = longint'(r % 4320);
    z = longint'(((f * PI48) / 64'd8640 + (64'd1 << 17)) >> 18);
    x = 64'sh26DD3B6A;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end
    end
    case (q)
      0: begin s = y;  c = x;  end
      1: begin s = x;  c = -y; end
      2: begin s = -y; c = -x; end
      default: begin s = -x; c = y; end
    endcase
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end
    end
    return (z < 0) ? 0 : z;
  endfunction

  function automatic logic [18:0] predict_distance(logic [47:0] la, logic [2:0] na,
                                                   logic [47:0] lb, logic [2:0] nb);
    longint lat1, lon1, lat2, lon2, sdlat, sdlon, c1, c2, tmp, a, sy, sx, z;
    longint unsigned d;
    decode_locator(la, na, lat1, lon1);
    decode_locator(lb, nb, lat2, lon2);
    rotate(lat2 - lat1, sdlat, tmp);
    rotate(lon2 - lon1, sdlon, tmp);
    rotate(lat1 * 2, tmp, c1);
    rotate(lat2 * 2, tmp, c2);
    a = mul_round(sdlat, sdlat) + mul_round(mul_round(c1, c2), mul_round(sdlon, sdlon));
    if (a < 0) a = 0;
    if (a > ONE) a = ONE;
    sy = isqrt(longint'(a) << 30);
    sx = isqrt(longint'(ONE - a) << 30);
    z = vector_angle(sy, sx);
    d = (longint'(z) * 12742 + (64'd1 << 25)) >> 26;
    if (d > 320300) d = 320300;
    return d[18:0];
  endfunction

  assign pending = distance_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      distance_q.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (in_valid && in_ready)
        distance_q.push_back(predict_distance(in_locator_a, in_length_a,
                                              in_locator_b, in_length_b));
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (distance_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected transfer: distance %0d", out_distance_km_q4);
          fail_count <= fail_count + 1;
        end else if (distance_q[0] !== out_distance_km_q4) begin
          if (fail_count < 10)
            $display("distance mismatch: expected %0d actual %0d",
                     distance_q[0], out_distance_km_q4);
          fail_count <= fail_count + 1;
          void'(distance_q.pop_front());
        end else begin
          void'(distance_q.pop_front());
        end
      end
    end
  end
endmodule

@@ tb/sv/locator_great_circle_distance_core_tb.sv @@
// Testbench top for the locator great-circle distance core: drives locator pairs
// under random idling and gives the verdict. Depends on the core and its checker.
module locator_great_circle_distance_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [47:0] in_locator_a = '0;
  logic [2:0] in_length_a = '0;
  logic [47:0] in_locator_b = '0;
  logic [2:0] in_length_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [18:0] out_distance_km_q4;
  int fail_count, pending, result_count;
  int send_idle_pct, recv_idle_pct;
  int sent_count = 0;
  int quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  locator_great_circle_distance_core u_dut (.*);

  locator_great_circle_distance_checker u_checker (.*);

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("locator_great_circle_distance_core regression: fail");
      $finish;
    end
  end

  task automatic send_pair(logic [47:0] la, logic [2:0] na, logic [47:0] lb, logic [2:0] nb);
    bit done;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_locator_a <= la;
    in_length_a <= na;
    in_locator_b <= lb;
    in_length_b <= nb;
    do begin
      @(negedge clk);
      done = in_ready;
      @(posedge clk);
    end while (!done);
    sent_count++;
  endtask

  function automatic logic [47:0] random_locator();
    logic [7:0] c [6];
    c[0] = 8'd65 + 8'($urandom_range(17));
    c[1] = 8'd65 + 8'($urandom_range(17));
    c[2] = 8'd48 + 8'($urandom_range(9));
    c[3] = 8'd48 + 8'($urandom_range(9));
    c[4] = 8'd97 + 8'($urandom_range(23));
    c[5] = 8'd97 + 8'($urandom_range(23));
    if ($urandom_range(1)) c[0] |= 8'h20;
    if ($urandom_range(1)) c[1] |= 8'h20;
    if ($urandom_range(1)) c[4] &= 8'hDF;
    if ($urandom_range(1)) c[5] &= 8'hDF;
    return {c[0], c[1], c[2], c[3], c[4], c[5]};
  endfunction

  task automatic send_random();
    logic [47:0] la, lb;
    logic [2:0] na, nb;
    la = random_locator();
    lb = random_locator();
    na = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(6, 4));
    nb = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(6, 4));
    if ($urandom_range(9) == 0) la = {$urandom, 16'($urandom)};
    if ($urandom_range(9) == 0) lb = {$urandom, 16'($urandom)};
    if ($urandom_range(19) == 0) lb = la;
    send_pair(la, na, lb, nb);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  initial begin
    send_idle_pct = 25;
    recv_idle_pct = 64;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pair("AA00aa", 3'd6, "RR99xx", 3'd6);
    send_pair("JN58td", 3'd6, "JN58td", 3'd6);
    send_pair("jn58TD", 3'd6, "JN58td", 3'd6);
    send_pair("AA00aa", 3'd0, "JJ00aa", 3'd3);
    send_pair("FN31pr", 3'd4, "FN31ab", 3'd5);
    send_pair("FN31pr", 3'd7, "PF95xx", 3'd6);
    send_pair("JJ00aa", 3'd6, "AJ00aa", 3'd6);
    send_pair("AJ00aa", 3'd4, "SJ00aa", 3'd4);
    send_pair("AR09ax", 3'd6, "RA90xa", 3'd6);
    send_pair('0, 3'd6, '1, 3'd6);
    send_pair('1, 3'd7, '0, 3'd4);
    send_pair("zz~~{{", 3'd6, "!!//@@", 3'd6);
    send_pair("JJ55mm", 3'd6, "AA00aa", 3'd1);
    send_pair("AA00aa", 3'd2, "AA00aa", 3'd0);
    send_pair("IO91wm", 3'd6, "QF56od", 3'd6);
    send_pair("AR00aa", 3'd6, "RR00aa", 3'd6);
    send_pair("JJ00aa", 3'd6, "TJ00aa", 3'd6);
    send_pair("AJ45ll", 3'd6, "KJ45ll", 3'd6);
    repeat (480) send_random();
    drain();

    send_idle_pct = 64;
    recv_idle_pct = 25;
    repeat (500) send_random();
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (500) send_random();
    drain();

    $display("covered %0d locator pairs, %0d distances, under three idling mixes",
             sent_count, result_count);
    if (fail_count == 0)
      $display("locator_great_circle_distance_core regression: pass");
    else
      $display("locator_great_circle_distance_core regression: fail");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/gcd_pkg.sv
rtl/gcd_front.sv
rtl/gcd_queue.sv
rtl/gcd_back.sv
rtl/locator_great_circle_distance_core.sv
tb/sv/locator_great_circle_distance_checker.sv
tb/sv/locator_great_circle_distance_core_tb.sv
